### design/pfdm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM frequency and duty meter: shared definitions
// Field widths, register indexes, reset values, payload structs and the
// state encoding of the measurement sequencer.
// ---------------------------------------------------------------------------
package pfdm_pkg;

    // Field widths of the request and result beats.
    localparam int REQ_TYPE_W   = 2;
    localparam int CAPTURE_W    = 32;
    localparam int FREQ_W       = 29;
    localparam int DUTY_W       = 7;

    // Configuration register widths.
    localparam int CLOCK_HZ_W   = 28;
    localparam int MIN_FREQ_W   = 20;
    localparam int TIMEOUT_W    = 16;
    localparam int THRESHOLD_W  = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 28;

    // Default width of the free-running capture timer.
    localparam int COUNTER_WIDTH_DEF = 32;

    // Reset values of the configuration registers.
    localparam logic [CLOCK_HZ_W-1:0]  CLOCK_HZ_RST  = CLOCK_HZ_W'(42000000);
    localparam logic [MIN_FREQ_W-1:0]  MIN_FREQ_RST  = MIN_FREQ_W'(1000);
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = TIMEOUT_W'(1000);
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = THRESHOLD_W'(1);

    // Millisecond counter and last reported duty.
    localparam int MS_W   = 17;
    localparam int RDUTY_W = 8;
    localparam logic [MS_W-1:0]    MS_MAX     = {MS_W{1'b1}};
    localparam logic [RDUTY_W-1:0] DUTY_RESET = RDUTY_W'(-10);

    // Duty arithmetic constants.
    localparam int DUTY_SCALE = 100;
    localparam int DUTY_Q_W   = 8;
    localparam logic [DUTY_Q_W-1:0] DUTY_FULL = DUTY_Q_W'(100);

    // Request kinds carried in req_type.
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_RISE = 2'd0,
        REQ_FALL = 2'd1,
        REQ_TICK = 2'd2
    } req_kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLOCK_HZ  = 2'd0,
        CFG_MIN_FREQ  = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_THRESHOLD = 2'd3
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH,
        ST_EMIT
    } state_t;

    // Request beat.
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [CAPTURE_W-1:0]  capture_value;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic [DUTY_W-1:0] duty_pct;
        logic              no_signal;
    } rsp_t;

endpackage

### design/pfdm_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit-serial restoring divider
// Shifts the dividend in one bit per cycle, MSB first, and produces one
// quotient bit per cycle. Quotient bits that fall off the top of the
// quotient register set a sticky overflow flag.
// ---------------------------------------------------------------------------
module pfdm_div
    import pfdm_pkg::*;
#(
    parameter int DW = 39,
    parameter int VW = 32,
    parameter int QW = 29
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient,
    output logic          overflow
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    dvd_reg;
    logic [VW-1:0]    rem_reg;
    logic [QW-1:0]    q_reg;
    logic             ovf_reg;

    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DW-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift registers for dividend, partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
            q_reg   <= {q_reg[QW-2:0], fits};
            ovf_reg <= ovf_reg | q_reg[QW-1];
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

### design/pwm_frequency_duty_meter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM frequency and duty meter
// Turns rising and falling edge captures into frequency and duty reports,
// and reports signal loss after a timeout counted in millisecond ticks.
//
//   Channel  Direction  Handshake            Beat
//   req      in         req_valid/req_stall  req_type, capture_value
//   rsp      out        rsp_valid/rsp_stall  freq_hz, duty_pct, no_signal
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A rising edge or an unused selector passes through decode only, a tick
// through decode and, when it reports, emit. A falling edge passes decode,
// load, divide, finish and, when it reports, emit: two bit-serial dividers run
// side by side, one quotient bit per cycle, over DIV_W dividend bits, where
// DIV_W = max(29, COUNTER_WIDTH + 7). A zero period skips the divide state.
// A result waits in the output register while rsp_stall is high; the next
// request beat is still taken, and only a further result waits for it.
// Reset is asynchronous and active low; configuration writes are always ready.
// ---------------------------------------------------------------------------
module pwm_frequency_duty_meter
    import pfdm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req_data,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW     = COUNTER_WIDTH;
    localparam int PROD_W = CW + 7;
    localparam int DIV_W  = (PROD_W > FREQ_W) ? PROD_W : FREQ_W;

    // Configuration registers.
    logic [CLOCK_HZ_W-1:0]  clock_hz_reg;
    logic [MIN_FREQ_W-1:0]  min_freq_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [THRESHOLD_W-1:0] threshold_reg;

    // Control state.
    state_t                 state_reg, state_next;
    logic                   present_reg, present_next;
    logic [MS_W-1:0]        ms_reg, ms_next;
    logic [RDUTY_W-1:0]     reported_reg, reported_next;
    logic [CW-1:0]          prev_rise_reg, prev_rise_next;
    logic [CW-1:0]          last_rise_reg, last_rise_next;
    logic                   out_valid_reg, out_valid_next;

    // Per-item working registers.
    req_kind_t              kind_reg;
    logic [CW-1:0]          cap_reg;
    logic [CW-1:0]          period_reg, period_next;
    logic [CW-1:0]          high_reg, high_next;
    rsp_t                   pend_reg, pend_next;
    rsp_t                   out_data_reg, out_data_next;

    // Divider interface.
    logic                   div_start;
    logic [DIV_W-1:0]       freq_dividend;
    logic [DIV_W-1:0]       duty_dividend;
    logic [PROD_W-1:0]      duty_product;
    logic                   freq_busy, duty_busy;
    logic [FREQ_W-1:0]      freq_q;
    logic [DUTY_Q_W-1:0]    duty_q;
    logic                   freq_ovf, duty_ovf;

    // Result evaluation.
    logic [MS_W-1:0]        ms_inc;
    logic                   period_zero;
    logic [FREQ_W-1:0]      freq_val;
    logic [DUTY_Q_W-1:0]    duty_adj;
    logic                   duty_drop;
    logic                   nosig;
    logic [DUTY_W-1:0]      duty_val;
    logic [RDUTY_W:0]       duty_diff;
    logic [RDUTY_W:0]       duty_abs;
    logic                   out_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Dividends: twice the bus clock, and one hundred times the high time.
    assign duty_product  = PROD_W'(high_reg) * PROD_W'(DUTY_SCALE);
    assign freq_dividend = DIV_W'({clock_hz_reg, 1'b0});
    assign duty_dividend = DIV_W'(duty_product);

    pfdm_div #(
        .DW (DIV_W),
        .VW (CW),
        .QW (FREQ_W)
    ) u_freq_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (freq_dividend),
        .divisor  (period_reg),
        .busy     (freq_busy),
        .quotient (freq_q),
        .overflow (freq_ovf)
    );

    pfdm_div #(
        .DW (DIV_W),
        .VW (CW),
        .QW (DUTY_Q_W)
    ) u_duty_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (duty_dividend),
        .divisor  (period_reg),
        .busy     (duty_busy),
        .quotient (duty_q),
        .overflow (duty_ovf)
    );

    // Measurement from the divider quotients.
    always_comb
    begin
        ms_inc      = (ms_reg == MS_MAX) ? ms_reg : ms_reg + MS_W'(1);
        period_zero = (period_reg == '0);
        freq_val    = freq_ovf ? {FREQ_W{1'b1}} : freq_q;
        duty_adj    = (duty_q > DUTY_FULL) ? duty_q - DUTY_FULL : duty_q;
        duty_drop   = duty_ovf || (duty_adj > DUTY_FULL);
        if (period_zero)
        begin
            freq_val  = '0;
            duty_adj  = '0;
            duty_drop = 1'b0;
        end
        nosig    = (freq_val < FREQ_W'(min_freq_reg));
        duty_val = nosig ? '0 : duty_adj[DUTY_W-1:0];
        duty_diff = {reported_reg[RDUTY_W-1], reported_reg} - (RDUTY_W + 1)'(duty_val);
        duty_abs  = duty_diff[RDUTY_W] ? -duty_diff : duty_diff;
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        ms_next        = ms_reg;
        reported_next  = reported_reg;
        prev_rise_next = prev_rise_reg;
        last_rise_next = last_rise_reg;
        period_next    = period_reg;
        high_next      = high_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        // The consumer takes the waiting beat.
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                case (kind_reg)
                    REQ_RISE:
                    begin
                        prev_rise_next = last_rise_reg;
                        last_rise_next = cap_reg;
                        state_next     = ST_IDLE;
                    end
                    REQ_FALL:
                    begin
                        present_next = 1'b1;
                        ms_next      = '0;
                        period_next  = last_rise_reg - prev_rise_reg;
                        high_next    = cap_reg - prev_rise_reg;
                        state_next   = ST_LOAD;
                    end
                    REQ_TICK:
                    begin
                        ms_next = ms_inc;
                        if (present_reg && (ms_inc > MS_W'(timeout_reg)))
                        begin
                            present_next        = 1'b0;
                            pend_next.freq_hz   = '0;
                            pend_next.duty_pct  = '0;
                            pend_next.no_signal = 1'b1;
                            state_next          = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_LOAD:
            begin
                if (period_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                if (!freq_busy && !duty_busy)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!duty_drop && (duty_abs > (RDUTY_W + 1)'(threshold_reg)))
                begin
                    reported_next       = RDUTY_W'(duty_val);
                    pend_next.freq_hz   = freq_val;
                    pend_next.duty_pct  = duty_val;
                    pend_next.no_signal = nosig;
                    state_next          = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and measurement state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= 1'b0;
            ms_reg        <= '0;
            reported_reg  <= DUTY_RESET;
            prev_rise_reg <= '0;
            last_rise_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            ms_reg        <= ms_next;
            reported_reg  <= reported_next;
            prev_rise_reg <= prev_rise_next;
            last_rise_reg <= last_rise_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg  <= CLOCK_HZ_RST;
            min_freq_reg  <= MIN_FREQ_RST;
            timeout_reg   <= TIMEOUT_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CLOCK_HZ:  clock_hz_reg  <= cfg_data[CLOCK_HZ_W-1:0];
                CFG_MIN_FREQ:  min_freq_reg  <= cfg_data[MIN_FREQ_W-1:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                default:       clock_hz_reg  <= clock_hz_reg;
            endcase
        end
    end

    // Payload registers: the accepted beat, working values and the result.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            kind_reg <= req_kind_t'(req_data.req_type);
            cap_reg  <= req_data.capture_value[CW-1:0];
        end
        period_reg   <= period_next;
        high_reg     <= high_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
    end

endmodule
